@@ rtl/core/ptt_pkg.sv @@
// Shared types and constants for the periodic timer table.
// No dependencies; compile first.
`default_nettype none

package ptt_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int MAX_RESULTS   = 16;
   localparam int FIRE_N_W      = $clog2(MAX_RESULTS + 1);

   localparam int MODE_W   = 2;
   localparam int ID_W     = 32;
   localparam int PERIOD_W = 32;
   localparam int COUNT_W  = 32;
   localparam int KIND_W   = 3;
   localparam int MPT_W    = 10;

   localparam logic [MPT_W-1:0] MPT_RESET = MPT_W'(50);

   localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SET  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_KILL = 2'd2;

   localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SET_OK    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SET_FULL  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_KILL_OK   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_KILL_NONE = 3'd4;

   typedef struct packed {
      logic                valid;
      logic [ID_W-1:0]     id;
      logic [PERIOD_W-1:0] period;
      logic [COUNT_W-1:0]  count;
   } slot_type;

endpackage

`default_nettype wire

@@ rtl/core/ptt_if.sv @@
// Valid/ready channel interfaces for request and response items.
// Depends on ptt_pkg.
`default_nettype none

interface ptt_req_if;
   import ptt_pkg::*;
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [ID_W-1:0]     timer_id;
   logic [PERIOD_W-1:0] period_ms;

   modport source (output valid, output mode, output timer_id, output period_ms,
                   input ready);
   modport sink   (input valid, input mode, input timer_id, input period_ms,
                   output ready);
endinterface

interface ptt_rsp_if;
   import ptt_pkg::*;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [ID_W-1:0]   result_id;
   logic              last;

   modport source (output valid, output kind, output result_id, output last,
                   input ready);
   modport sink   (input valid, input kind, input result_id, input last,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/core/periodic_timer_table.sv @@
// Top level of the periodic timer table: ring of slot cells, sequencer, tick register.
// Depends on ptt_pkg, ptt_if, ptt_cell and ptt_ctrl.
//
//   channel   direction  handshake              payload
//   req_ch    in         valid/ready            mode, timer_id, period_ms
//   rsp_ch    out        valid/ready            kind, result_id, last
//   csr_*     in         csr_we (no wait)       csr_wdata = ms_per_tick
//
// One item at a time. Every item but an unused mode makes one pass over the ring, and a set
// that claims a free slot makes a second pass to fill it. Each pass takes the slots one per
// cycle as the ring rotates past the update unit, unless a firing tick stalls on a busy
// response output. Reset clears every slot at once; no clearing pass.
`default_nettype none

module periodic_timer_table #(
   parameter int SLOTS = ptt_pkg::SLOTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   ptt_req_if.sink                   req_ch,
   ptt_rsp_if.source                 rsp_ch,
   input  logic                      csr_we,
   input  logic [ptt_pkg::MPT_W-1:0] csr_wdata
);
   import ptt_pkg::*;

   logic [MPT_W-1:0] ms_per_tick_ff, ms_per_tick_in;
   slot_type         chain[SLOTS];
   slot_type         head_slot;
   logic             shift_en;

   always_comb begin
      ms_per_tick_in = csr_we ? csr_wdata : ms_per_tick_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_per_tick_ff <= MPT_RESET;
      end else begin
         ms_per_tick_ff <= ms_per_tick_in;
      end
   end

   // cell 0 sits at the head of the ring, so slots pass the update unit in order
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      ptt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .slot_in  ((i == 0) ? head_slot : chain[(i == 0) ? 0 : i - 1]),
         .slot_out (chain[i])
      );
   end

   ptt_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .ms_per_tick (ms_per_tick_ff),
      .tail_slot   (chain[SLOTS-1]),
      .head_slot   (head_slot),
      .shift_en    (shift_en)
   );

endmodule

`default_nettype wire

@@ rtl/core/ptt_cell.sv @@
// One slot of the timer ring: holds a slot and passes it on when the ring rotates.
// Depends on ptt_pkg.
`default_nettype none

module ptt_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  ptt_pkg::slot_type slot_in,
   output ptt_pkg::slot_type slot_out
);
   import ptt_pkg::*;

   slot_type slot_ff;
   slot_type slot_in_d;

   always_comb begin
      slot_in_d = shift_en ? slot_in : slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in_d;
      end
   end

   assign slot_out = slot_ff;

endmodule

`default_nettype wire

@@ rtl/core/ptt_ctrl.sv @@
// Sequencer and slot update unit at the tail of the ring, with response buffering.
// Depends on ptt_pkg and ptt_if.
`default_nettype none

module ptt_ctrl #(
   parameter int SLOTS = ptt_pkg::SLOTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   ptt_req_if.sink                   req_ch,
   ptt_rsp_if.source                 rsp_ch,
   input  logic [ptt_pkg::MPT_W-1:0] ms_per_tick,
   input  ptt_pkg::slot_type         tail_slot,
   output ptt_pkg::slot_type         head_slot,
   output logic                      shift_en
);
   import ptt_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_FILL = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     step_ff, step_in;
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [PERIOD_W-1:0]  period_ff, period_in;
   logic                 found_ff, found_in;
   logic                 free_found_ff, free_found_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic [FIRE_N_W-1:0]  fire_n_ff, fire_n_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [KIND_W-1:0]    pend_kind_ff, pend_kind_in;
   logic [ID_W-1:0]      pend_id_ff, pend_id_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [COUNT_W:0]     sum;
   logic [COUNT_W-1:0]   tick_count;
   logic                 fire;
   logic                 id_hit;
   logic                 last_step;
   logic                 out_free;
   logic                 stall;

   always_comb begin
      sum        = {1'b0, tail_slot.count} + (COUNT_W + 1)'(ms_per_tick);
      tick_count = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
      fire       = tail_slot.valid && (tick_count >= tail_slot.period);
      id_hit     = tail_slot.id == id_ff;
      last_step  = step_ff == IDX_W'(SLOTS - 1);
      out_free   = !rsp_valid_ff || rsp_ch.ready;
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      mode_in       = mode_ff;
      id_in         = id_ff;
      period_in     = period_ff;
      found_in      = found_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      fire_n_in     = fire_n_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_id_in    = pend_id_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      head_slot     = tail_slot;
      shift_en      = 1'b0;
      stall         = 1'b0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               mode_in       = req_ch.mode;
               id_in         = req_ch.timer_id;
               period_in     = req_ch.period_ms;
               step_in       = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               fire_n_in     = '0;
               pend_valid_in = 1'b0;
               if (req_ch.mode inside {MODE_TICK, MODE_SET, MODE_KILL}) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            case (mode_ff)
               MODE_TICK: begin
                  if (tail_slot.valid) begin
                     head_slot.count = fire ? '0 : tick_count;
                     if (fire && (fire_n_ff < FIRE_N_W'(MAX_RESULTS))) begin
                        if (pend_valid_ff) begin
                           if (out_free) begin
                              rsp_valid_in = 1'b1;
                              rsp_kind_in  = KIND_FIRED;
                              rsp_id_in    = pend_id_ff;
                              rsp_last_in  = 1'b0;
                              pend_id_in   = tail_slot.id;
                              fire_n_in    = fire_n_ff + 1'b1;
                           end else begin
                              stall = 1'b1;
                           end
                        end else begin
                           pend_valid_in = 1'b1;
                           pend_kind_in  = KIND_FIRED;
                           pend_id_in    = tail_slot.id;
                           fire_n_in     = fire_n_ff + 1'b1;
                        end
                     end
                  end
               end
               MODE_SET: begin
                  if (!found_ff && id_hit) begin
                     found_in         = 1'b1;
                     head_slot.valid  = 1'b1;
                     head_slot.period = period_ff;
                     head_slot.count  = '0;
                  end else if (!found_ff && !tail_slot.valid && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = step_ff;
                  end
               end
               MODE_KILL: begin
                  if (!found_ff && id_hit) begin
                     found_in  = 1'b1;
                     head_slot = '0;
                  end
               end
               default: begin
               end
            endcase

            if (!stall) begin
               shift_en = 1'b1;
               step_in  = last_step ? '0 : step_ff + 1'b1;
               if (last_step) begin
                  case (mode_ff)
                     MODE_TICK: begin
                        state_in = pend_valid_in ? ST_RESP : ST_IDLE;
                     end
                     MODE_SET: begin
                        pend_id_in = id_ff;
                        if (found_in) begin
                           pend_valid_in = 1'b1;
                           pend_kind_in  = KIND_SET_OK;
                           state_in      = ST_RESP;
                        end else if (free_found_in) begin
                           state_in = ST_FILL;
                        end else begin
                           pend_valid_in = 1'b1;
                           pend_kind_in  = KIND_SET_FULL;
                           state_in      = ST_RESP;
                        end
                     end
                     MODE_KILL: begin
                        pend_valid_in = 1'b1;
                        pend_id_in    = id_ff;
                        pend_kind_in  = found_in ? KIND_KILL_OK : KIND_KILL_NONE;
                        state_in      = ST_RESP;
                     end
                     default: begin
                        state_in = ST_IDLE;
                     end
                  endcase
               end
            end
         end
         ST_FILL: begin
            shift_en = 1'b1;
            step_in  = last_step ? '0 : step_ff + 1'b1;
            if (step_ff == free_idx_ff) begin
               head_slot.valid  = 1'b1;
               head_slot.id     = id_ff;
               head_slot.period = period_ff;
               head_slot.count  = '0;
            end
            if (last_step) begin
               pend_valid_in = 1'b1;
               pend_kind_in  = KIND_SET_OK;
               pend_id_in    = id_ff;
               state_in      = ST_RESP;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = pend_kind_ff;
               rsp_id_in     = pend_id_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      mode_ff       <= mode_in;
      id_ff         <= id_in;
      period_ff     <= period_in;
      found_ff      <= found_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      fire_n_ff     <= fire_n_in;
      pend_kind_ff  <= pend_kind_in;
      pend_id_ff    <= pend_id_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_ch.ready     = state_ff == ST_IDLE;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.kind      = rsp_kind_ff;
   assign rsp_ch.result_id = rsp_id_ff;
   assign rsp_ch.last      = rsp_last_ff;

endmodule

`default_nettype wire

@@ sim/tb_periodic_timer_table.sv @@
// Self-checking testbench for the periodic timer table: set, kill and tick items,
// with a scoreboard that predicts every response item.
// Depends on ptt_pkg, ptt_if and periodic_timer_table.
`default_nettype none

module tb_periodic_timer_table;
   timeunit 1ns;
   timeprecision 1ps;

   import ptt_pkg::*;

   localparam int SLOTS       = SLOTS_DEFAULT;
   localparam int POOL_N      = 20;
   localparam int SETTLE      = 2 * SLOTS + 8;
   localparam int LONG_HOLD   = 300;
   localparam int STALL_LIMIT = 3000;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   rid;
      logic              last;
   } timer_result_t;

   class timer_scoreboard;
      logic [MPT_W-1:0]    tick_ms;
      logic                slot_live[SLOTS];
      logic [ID_W-1:0]     slot_tid[SLOTS];
      logic [PERIOD_W-1:0] slot_per[SLOTS];
      logic [COUNT_W-1:0]  slot_elapsed[SLOTS];
      timer_result_t       due_q[$];
      int                  errors;

      function new();
         tick_ms = MPT_RESET;
         errors  = 0;
         for (int i = 0; i < SLOTS; i++) begin
            slot_live[i]    = 1'b0;
            slot_tid[i]     = '0;
            slot_per[i]     = '0;
            slot_elapsed[i] = '0;
         end
      endfunction

      function void note_item(logic [MODE_W-1:0] mode, logic [ID_W-1:0] tid,
                              logic [PERIOD_W-1:0] period);
         timer_result_t fired[$];
         timer_result_t r;
         logic [COUNT_W:0] sum;
         logic [COUNT_W-1:0] c;
         int hit;
         int free_slot;
         hit = -1;
         free_slot = -1;
         case (mode)
            MODE_TICK: begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot_live[i]) begin
                     sum = {1'b0, slot_elapsed[i]} + (COUNT_W + 1)'(tick_ms);
                     c = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
                     if (c >= slot_per[i]) begin
                        c = '0;
                        if (fired.size() < MAX_RESULTS) begin
                           r.kind = KIND_FIRED;
                           r.rid  = slot_tid[i];
                           r.last = 1'b0;
                           fired.push_back(r);
                        end
                     end
                     slot_elapsed[i] = c;
                  end
               end
               for (int j = 0; j < fired.size(); j++) begin
                  r = fired[j];
                  r.last = (j == fired.size() - 1);
                  due_q.push_back(r);
               end
            end
            MODE_SET: begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot_tid[i] == tid) begin
                     hit = i;
                     break;
                  end
                  if (!slot_live[i] && free_slot < 0) free_slot = i;
               end
               if (hit < 0 && free_slot >= 0) begin
                  hit = free_slot;
                  slot_tid[hit] = tid;
               end
               r.rid  = tid;
               r.last = 1'b1;
               if (hit < 0) begin
                  r.kind = KIND_SET_FULL;
               end else begin
                  slot_live[hit]    = 1'b1;
                  slot_per[hit]     = period;
                  slot_elapsed[hit] = '0;
                  r.kind = KIND_SET_OK;
               end
               due_q.push_back(r);
            end
            MODE_KILL: begin
               r.rid  = tid;
               r.last = 1'b1;
               r.kind = KIND_KILL_NONE;
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot_tid[i] == tid) begin
                     slot_live[i]    = 1'b0;
                     slot_tid[i]     = '0;
                     slot_per[i]     = '0;
                     slot_elapsed[i] = '0;
                     r.kind = KIND_KILL_OK;
                     break;
                  end
               end
               due_q.push_back(r);
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [KIND_W-1:0] kind, logic [ID_W-1:0] rid, logic last);
         timer_result_t want;
         if (due_q.size() == 0) begin
            errors++;
            $error("unexpected item: kind %0d result_id %0h last %0b", kind, rid, last);
            return;
         end
         want = due_q.pop_front();
         if (kind !== want.kind) begin
            errors++;
            $error("kind: expected %0d, got %0d", want.kind, kind);
         end
         if (rid !== want.rid) begin
            errors++;
            $error("result_id: expected %0h, got %0h", want.rid, rid);
         end
         if (last !== want.last) begin
            errors++;
            $error("last: expected %0b, got %0b", want.last, last);
         end
      endfunction

      function int pending();
         return due_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [MPT_W-1:0] csr_wdata;

   ptt_req_if req_ch();
   ptt_rsp_if rsp_ch();

   periodic_timer_table #(.SLOTS(SLOTS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   timer_scoreboard sb;
   logic [ID_W-1:0] id_pool[POOL_N];
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int quiet_cycles  = 0;

   always #5 clock = ~clock;

   // response side: random stalls plus an occasional long hold-off
   initial begin : response_side
      int hold_served;
      int hold_left;
      hold_served = 0;
      hold_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result(rsp_ch.kind, rsp_ch.result_id, rsp_ch.last);
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] tid,
                            input logic [PERIOD_W-1:0] period);
      @(negedge clock);
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.mode      <= mode;
      req_ch.timer_id  <= tid;
      req_ch.period_ms <= period;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_item(mode, tid, period);
   endtask

   // drop valid, wait for every response, then let the block go idle
   task automatic quiesce();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_tick_ms(input logic [MPT_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.tick_ms = value;
   endtask

   function automatic logic [PERIOD_W-1:0] pick_period();
      case ($urandom_range(9))
         0:       return $urandom;
         1, 2:    return $urandom_range(0, 400);
         default: return PERIOD_W'(sb.tick_ms) * $urandom_range(0, 5)
                         + $urandom_range(0, sb.tick_ms);
      endcase
   endfunction

   function automatic logic [ID_W-1:0] pick_id();
      if ($urandom_range(9) < 8) return id_pool[$urandom_range(POOL_N - 1)];
      return $urandom;
   endfunction

   task automatic random_items(input int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 45)      send_item(MODE_TICK, $urandom, $urandom);
         else if (r < 80) send_item(MODE_SET, pick_id(), pick_period());
         else if (r < 95) send_item(MODE_KILL, pick_id(), $urandom);
         else             send_item(MODE_UNUSED, $urandom, $urandom);
      end
   endtask

   task automatic run_phase(input logic [MPT_W-1:0] ms, input int idle_pct,
                            input int stall_pct, input int n);
      quiesce();
      write_tick_ms(ms);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      random_items(n);
   endtask

   initial begin : stimulus
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_wdata        = '0;
      req_ch.valid     = 1'b0;
      req_ch.mode      = MODE_TICK;
      req_ch.timer_id  = '0;
      req_ch.period_ms = '0;
      sb = new();
      for (int i = 0; i < POOL_N; i++) id_pool[i] = $urandom;
      id_pool[POOL_N - 2] = '0;
      id_pool[POOL_N - 1] = '1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // period 0 fires on every tick; id 0 shares the free-slot id
      send_item(MODE_SET, '1, '0);
      send_item(MODE_SET, '0, '1);
      send_item(MODE_SET, 32'h5A5A_0001, 32'd120);
      send_item(MODE_SET, 32'h5A5A_0001, 32'd50);
      send_item(MODE_TICK, '1, '1);
      send_item(MODE_KILL, 32'hDEAD_BEEF, '0);
      send_item(MODE_KILL, 32'h5A5A_0001, '1);
      send_item(MODE_UNUSED, '1, '1);
      send_item(MODE_KILL, '0, '0);
      send_item(MODE_TICK, '0, '0);
      // fill the table, overflow it, then update in a full table
      for (int i = 0; i < 15; i++) send_item(MODE_SET, id_pool[i], PERIOD_W'(50 * (i % 4)));
      send_item(MODE_SET, id_pool[15], 32'd100);
      send_item(MODE_SET, id_pool[3], 32'd0);
      send_item(MODE_TICK, '0, '0);

      run_phase(10'd1, 0, 0, 24);
      run_phase(10'd1000, 59, 0, 24);
      run_phase(10'd1023, 0, 59, 24);
      run_phase(10'd0, 21, 21, 12);

      quiesce();
      write_tick_ms(MPT_W'($urandom_range(1, 1000)));
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_requests = hold_requests + 1;
      random_items(12);
      quiesce();
      random_items(12);

      quiesce();
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
